@@ rtl/core/mntr_pkg.sv @@
// Shared types and constants of the memory node with tree routing.
package mntr_pkg;

  localparam int unsigned MemDepth = 4096;
  localparam int unsigned IdxW     = $clog2(MemDepth);
  localparam int unsigned WiuW     = 13;
  localparam int unsigned SegW     = 24;
  localparam int unsigned LimW     = (IdxW + 1 > WiuW) ? IdxW + 1 : WiuW;
  localparam int unsigned AddrW    = 64;
  localparam int unsigned DataW    = 64;
  localparam int unsigned TagW     = 8;
  localparam int unsigned OffW     = 40;

  typedef enum logic [1:0] {
    ReqRead   = 2'd0,
    ReqWrite  = 2'd1,
    ReqSignal = 2'd2,
    ReqInject = 2'd3
  } req_type_e;

  typedef enum logic [2:0] {
    RkReadDone  = 3'd0,
    RkWriteDone = 3'd1,
    RkRange     = 3'd2,
    RkSignal    = 3'd3,
    RkRouter    = 3'd4
  } result_kind_e;

  // Classified request, handed from the front to the back.
  typedef struct packed {
    result_kind_e     kind;
    logic [IdxW-1:0]  idx;
    logic [DataW-1:0] data;
    logic [TagW-1:0]  tag;
    logic [3:0]       cpu;
    logic [7:0]       up;
    logic [SegW-1:0]  down;
    logic [1:0]       mode;
    logic [AddrW-1:0] addr;
  } cmd_t;

endpackage

@@ rtl/core/mntr_front.sv @@
// Request classifier: local access, range check, signal and route computation.
module mntr_front (
  input  logic [1:0]                 req_type_i,
  input  logic                       from_router_i,
  input  logic [mntr_pkg::AddrW-1:0] address_i,
  input  logic [mntr_pkg::DataW-1:0] word_data_i,
  input  logic [mntr_pkg::TagW-1:0]  word_tag_i,
  input  logic [mntr_pkg::SegW-1:0]  segment_id_i,
  input  logic [mntr_pkg::WiuW-1:0]  words_in_use_i,
  output mntr_pkg::cmd_t             cmd_o
);

  mntr_pkg::req_type_e            rt;
  logic [mntr_pkg::SegW-1:0]      dseg;
  logic [mntr_pkg::SegW-1:0]      diff;
  logic [mntr_pkg::OffW-1:0]      off;
  logic [mntr_pkg::LimW-1:0]      limit;
  logic                           own_seg;
  logic                           in_range;
  logic [6:0]                     up;
  logic [2:0]                     up_len;
  logic [3:0]                     levels;
  logic [3:0]                     lvl_gap;
  logic [4:0]                     sh;
  logic [mntr_pkg::SegW-1:0]      path_full;

  assign rt      = mntr_pkg::req_type_e'(req_type_i);
  assign dseg    = address_i[mntr_pkg::AddrW-1 -: mntr_pkg::SegW];
  assign off     = address_i[mntr_pkg::OffW-1:0];
  assign own_seg = (dseg == segment_id_i);
  assign diff    = segment_id_i ^ dseg;

  always_comb begin
    if (mntr_pkg::LimW'(words_in_use_i) > mntr_pkg::LimW'(mntr_pkg::MemDepth)) begin
      limit = mntr_pkg::LimW'(mntr_pkg::MemDepth);
    end else begin
      limit = mntr_pkg::LimW'(words_in_use_i);
    end
  end

  assign in_range = own_seg && (off < mntr_pkg::OffW'(limit));

  // Up count bit k covers coordinate bit k+1, i.e. segment bits 3k+5..3k+3.
  always_comb begin
    for (int k = 0; k < 7; k++) begin
      up[k] = |diff[3*k+3 +: 3];
    end
  end

  always_comb begin
    up_len = 3'd0;
    for (int k = 0; k < 7; k++) begin
      if (up[k]) up_len = 3'(k + 1);
    end
  end

  // Level 0 group sits at the top; drop the unused low levels by shifting.
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      path_full[mntr_pkg::SegW-1-3*i -: 3] = dseg[3*i +: 3];
    end
  end

  assign levels  = {1'b0, up_len} + 4'd1;
  assign lvl_gap = 4'd8 - levels;
  assign sh      = 5'({1'b0, lvl_gap} + {lvl_gap, 1'b0});

  always_comb begin
    cmd_o      = '0;
    cmd_o.kind = mntr_pkg::RkRange;
    if (from_router_i || own_seg) begin
      if (rt == mntr_pkg::ReqRead || rt == mntr_pkg::ReqWrite) begin
        if (in_range) begin
          cmd_o.idx = off[mntr_pkg::IdxW-1:0];
          if (rt == mntr_pkg::ReqRead) begin
            cmd_o.kind = mntr_pkg::RkReadDone;
          end else begin
            cmd_o.kind = mntr_pkg::RkWriteDone;
            cmd_o.data = word_data_i;
            cmd_o.tag  = word_tag_i;
          end
        end
      end else begin
        cmd_o.kind = mntr_pkg::RkSignal;
        cmd_o.data = word_data_i;
        cmd_o.cpu  = address_i[3:0];
      end
    end else begin
      cmd_o.kind = mntr_pkg::RkRouter;
      cmd_o.data = word_data_i;
      cmd_o.tag  = word_tag_i;
      cmd_o.up   = (rt == mntr_pkg::ReqInject) ? 8'hFF : {1'b0, up};
      cmd_o.down = path_full >> sh;
      cmd_o.mode = req_type_i;
      cmd_o.addr = address_i;
    end
  end

endmodule

@@ rtl/core/mntr_cmd_fifo.sv @@
// Two-entry queue of classified requests between front and back.
module mntr_cmd_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  mntr_pkg::cmd_t push_cmd_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output mntr_pkg::cmd_t pop_cmd_o
);

  mntr_pkg::cmd_t entry_q [2];
  logic           wr_ptr_q, wr_ptr_d;
  logic           rd_ptr_q, rd_ptr_d;
  logic [1:0]     cnt_q, cnt_d;
  logic           do_push, do_pop;

  assign full_o    = (cnt_q == 2'd2);
  assign valid_o   = (cnt_q != 2'd0);
  assign pop_cmd_o = entry_q[rd_ptr_q];
  assign do_push   = push_i && !full_o;
  assign do_pop    = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = do_push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? !rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

@@ rtl/core/mntr_back.sv @@
// Executor: word store with clearing pass, read stage and result register.
module mntr_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cmd_valid_i,
  input  mntr_pkg::cmd_t             cmd_i,
  output logic                       cmd_pop_o,
  output logic                       clr_busy_o,
  input  logic                       pop_i,
  output logic                       empty_o,
  output mntr_pkg::cmd_t             res_o
);

  localparam int unsigned MemW = mntr_pkg::DataW + mntr_pkg::TagW;
  localparam logic [mntr_pkg::IdxW-1:0] IdxLast = mntr_pkg::IdxW'(mntr_pkg::MemDepth - 1);

  logic [MemW-1:0]           mem_q [mntr_pkg::MemDepth];
  logic [MemW-1:0]           rdata_q;
  logic                      clr_busy_q;
  logic [mntr_pkg::IdxW-1:0] clr_idx_q;
  logic                      s1_valid_q, s1_valid_d;
  mntr_pkg::cmd_t            s1_q;
  logic                      out_valid_q, out_valid_d;
  mntr_pkg::cmd_t            out_q, out_d;
  logic                      s1_move, issue;
  logic                      mem_we;
  logic [mntr_pkg::IdxW-1:0] mem_wa;
  logic [MemW-1:0]           mem_wd;

  assign s1_move   = s1_valid_q && (!out_valid_q || pop_i);
  assign issue     = cmd_valid_i && !clr_busy_q && (!s1_valid_q || s1_move);
  assign cmd_pop_o = issue;

  always_comb begin
    if (clr_busy_q) begin
      mem_we = 1'b1;
      mem_wa = clr_idx_q;
      mem_wd = '0;
    end else begin
      mem_we = issue && (cmd_i.kind == mntr_pkg::RkWriteDone);
      mem_wa = cmd_i.idx;
      mem_wd = {cmd_i.data, cmd_i.tag};
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_wa] <= mem_wd;
    end
    if (issue && cmd_i.kind == mntr_pkg::RkReadDone) begin
      rdata_q <= mem_q[cmd_i.idx];
    end
  end

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (issue) begin
      s1_valid_d = 1'b1;
    end else if (s1_move) begin
      s1_valid_d = 1'b0;
    end
  end

  // Write done reports no data; fill read data from the store.
  always_comb begin
    out_d = s1_q;
    unique case (s1_q.kind)
      mntr_pkg::RkReadDone: begin
        out_d.data = rdata_q[MemW-1 -: mntr_pkg::DataW];
        out_d.tag  = rdata_q[mntr_pkg::TagW-1:0];
      end
      mntr_pkg::RkWriteDone: begin
        out_d.data = '0;
        out_d.tag  = '0;
        out_d.idx  = '0;
      end
      mntr_pkg::RkRange, mntr_pkg::RkSignal, mntr_pkg::RkRouter: begin
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (s1_move) begin
      out_valid_d = 1'b1;
    end else if (pop_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q  <= 1'b1;
      clr_idx_q   <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (clr_busy_q) begin
        clr_idx_q <= clr_idx_q + 1'b1;
        if (clr_idx_q == IdxLast) clr_busy_q <= 1'b0;
      end
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) s1_q <= cmd_i;
    if (s1_move) out_q <= out_d;
  end

  assign clr_busy_o = clr_busy_q;
  assign empty_o    = !out_valid_q;
  assign res_o      = out_q;

endmodule

@@ rtl/core/memory_node_with_tree_routing.sv @@
// Top level of the memory node with tree routing: config registers and datapath.
//
//   channel   | handshake                 | contents
//   ----------+---------------------------+---------------------------------------
//   request   | push_i / full_o           | req_type, from_router, address, data, tag
//   result    | pop_i / empty_o           | result_kind, data, tag, cpu, route fields
//   config    | APB psel/penable/pwrite   | segment_id @0x0, words_in_use @0x4
//
// One request per cycle sustained while results are popped; a taken request
// passes a slot in the queue, then the store access stage, then the result
// register. The store read data is registered in the access stage.
// After reset a clearing pass zeroes all MemDepth (4096) words of the store,
// one word per cycle; full_o stays high meanwhile, config writes still land.
// A stalled result holds the read stage, which holds the command queue; once
// the queue fills, full_o rises. Results are never dropped or reordered.
module memory_node_with_tree_routing (
  input  logic        clk_i,
  input  logic        rst_ni,
  // request side
  input  logic        push_i,
  output logic        full_o,
  input  logic [1:0]  req_type_i,
  input  logic        from_router_i,
  input  logic [63:0] address_i,
  input  logic [63:0] word_data_i,
  input  logic [7:0]  word_tag_i,
  // result side
  input  logic        pop_i,
  output logic        empty_o,
  output logic [2:0]  result_kind_o,
  output logic [63:0] out_data_o,
  output logic [7:0]  out_tag_o,
  output logic [3:0]  cpu_index_o,
  output logic [7:0]  up_hops_o,
  output logic [23:0] down_path_o,
  output logic [1:0]  link_mode_o,
  output logic [63:0] link_address_o,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [mntr_pkg::SegW-1:0] segment_id_q;
  logic [mntr_pkg::WiuW-1:0] words_in_use_q;
  logic                      cfg_we;

  mntr_pkg::cmd_t front_cmd;
  mntr_pkg::cmd_t q_cmd;
  mntr_pkg::cmd_t res;
  logic           q_full, q_valid, q_pop;
  logic           clr_busy;
  logic           req_take;

  // Register file: word address in paddr[2], low address bits ignored.
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      segment_id_q   <= '0;
      words_in_use_q <= mntr_pkg::WiuW'(4096);
    end else if (cfg_we) begin
      if (paddr[2]) begin
        words_in_use_q <= pwdata[mntr_pkg::WiuW-1:0];
      end else begin
        segment_id_q <= pwdata[mntr_pkg::SegW-1:0];
      end
    end
  end

  assign prdata = paddr[2] ? 32'(words_in_use_q) : 32'(segment_id_q);

  // Front: classify the request and compute route fields.
  mntr_front u_front (
    .req_type_i     (req_type_i),
    .from_router_i  (from_router_i),
    .address_i      (address_i),
    .word_data_i    (word_data_i),
    .word_tag_i     (word_tag_i),
    .segment_id_i   (segment_id_q),
    .words_in_use_i (words_in_use_q),
    .cmd_o          (front_cmd)
  );

  // Hold off requests while the queue is full or the store is being cleared.
  assign full_o   = q_full || clr_busy;
  assign req_take = push_i && !full_o;

  mntr_cmd_fifo u_cmd_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (req_take),
    .push_cmd_i (front_cmd),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .valid_o    (q_valid),
    .pop_cmd_o  (q_cmd)
  );

  // Back: access the store and present results.
  mntr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (q_valid),
    .cmd_i       (q_cmd),
    .cmd_pop_o   (q_pop),
    .clr_busy_o  (clr_busy),
    .pop_i       (pop_i),
    .empty_o     (empty_o),
    .res_o       (res)
  );

  assign result_kind_o  = res.kind;
  assign out_data_o     = res.data;
  assign out_tag_o      = res.tag;
  assign cpu_index_o    = res.cpu;
  assign up_hops_o      = res.up;
  assign down_path_o    = res.down;
  assign link_mode_o    = res.mode;
  assign link_address_o = res.addr;

endmodule

@@ tb/mntr_node_checker.sv @@
`timescale 1ns / 100ps
// Checker for the memory node: mirrors config and store, predicts and compares results.
module mntr_node_checker
  import mntr_pkg::*;
#(
  parameter logic [2:0] SegIdAddr      = 3'h0,
  parameter logic [2:0] WordsInUseAddr = 3'h4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  logic        full_o,
  input  logic [1:0]  req_type_i,
  input  logic        from_router_i,
  input  logic [63:0] address_i,
  input  logic [63:0] word_data_i,
  input  logic [7:0]  word_tag_i,
  input  logic        pop_i,
  input  logic        empty_o,
  input  logic [2:0]  result_kind_o,
  input  logic [63:0] out_data_o,
  input  logic [7:0]  out_tag_o,
  input  logic [3:0]  cpu_index_o,
  input  logic [7:0]  up_hops_o,
  input  logic [23:0] down_path_o,
  input  logic [1:0]  link_mode_o,
  input  logic [63:0] link_address_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic [31:0] prdata,
  input  logic        pready,
  output int unsigned fail_count_o,
  output int unsigned outstanding_o
);

  typedef struct packed {
    result_kind_e     kind;
    logic [DataW-1:0] data;
    logic [TagW-1:0]  tag;
    logic [3:0]       cpu;
    logic [7:0]       up;
    logic [SegW-1:0]  down;
    logic [1:0]       mode;
    logic [AddrW-1:0] addr;
  } node_result_t;

  logic [DataW-1:0] mirror_data [MemDepth];
  logic [TagW-1:0]  mirror_tag  [MemDepth];
  logic [SegW-1:0]  own_seg;
  logic [WiuW-1:0]  words_in_use;
  node_result_t     awaited_results [$];

  // Bit k of the coordinate is bit 3k+lane of the segment number.
  function automatic logic [7:0] lane_coord(logic [SegW-1:0] seg, int lane);
    logic [7:0] c;
    for (int k = 0; k < 8; k++) c[k] = seg[3*k + lane];
    return c;
  endfunction

  // Serve one request against the mirrored store and config.
  function automatic node_result_t serve_request(req_type_e rt, logic fr,
                                                 logic [63:0] addr, logic [63:0] wd,
                                                 logic [7:0] wt);
    node_result_t    res;
    logic [SegW-1:0] dseg;
    logic [SegW-1:0] diff;
    logic [SegW-1:0] path;
    logic [OffW-1:0] off;
    logic [7:0]      up;
    int unsigned     limit;
    int unsigned     levels;
    res.kind = RkRange;
    res.data = '0;
    res.tag  = '0;
    res.cpu  = '0;
    res.up   = '0;
    res.down = '0;
    res.mode = '0;
    res.addr = '0;
    dseg  = addr[63:40];
    off   = addr[OffW-1:0];
    limit = (words_in_use > MemDepth) ? MemDepth : words_in_use;
    if (fr || dseg == own_seg) begin
      if (rt == ReqRead || rt == ReqWrite) begin
        if (dseg != own_seg || off >= limit) begin
          res.kind = RkRange;
        end else if (rt == ReqRead) begin
          res.kind = RkReadDone;
          res.data = mirror_data[off[IdxW-1:0]];
          res.tag  = mirror_tag[off[IdxW-1:0]];
        end else begin
          mirror_data[off[IdxW-1:0]] = wd;
          mirror_tag[off[IdxW-1:0]]  = wt;
          res.kind = RkWriteDone;
        end
      end else begin
        res.kind = RkSignal;
        res.data = wd;
        res.cpu  = addr[3:0];
      end
    end else begin
      diff   = own_seg ^ dseg;
      up     = (lane_coord(diff, 0) | lane_coord(diff, 1) | lane_coord(diff, 2)) >> 1;
      levels = 1;
      for (int b = 0; b < 8; b++) if (up[b]) levels = b + 2;
      path = '0;
      for (int i = 0; i < 8; i++) if (i < levels) path = {path[SegW-4:0], dseg[3*i +: 3]};
      res.kind = RkRouter;
      res.data = wd;
      res.tag  = wt;
      res.up   = (rt == ReqInject) ? 8'hFF : up;
      res.down = path;
      res.mode = rt;
      res.addr = addr;
    end
    return res;
  endfunction

  task automatic check_field(string field, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", field, want, got);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    node_result_t want;
    if (!rst_ni) begin
      own_seg      = '0;
      words_in_use = WiuW'(MemDepth);
      awaited_results.delete();
      for (int i = 0; i < MemDepth; i++) begin
        mirror_data[i] = '0;
        mirror_tag[i]  = '0;
      end
    end else begin
      // Retire first: a result leaving now can never be from a request taken now.
      if (pop_i && !empty_o) begin
        if (awaited_results.size() == 0) begin
          $error("result of kind %0d with no request outstanding", result_kind_o);
          fail_count_o++;
        end else begin
          want = awaited_results.pop_front();
          check_field("result_kind", want.kind, result_kind_o);
          check_field("out_data", want.data, out_data_o);
          check_field("out_tag", want.tag, out_tag_o);
          check_field("cpu_index", want.cpu, cpu_index_o);
          check_field("up_hops", want.up, up_hops_o);
          check_field("down_path", want.down, down_path_o);
          check_field("link_mode", want.mode, link_mode_o);
          check_field("link_address", want.addr, link_address_o);
        end
      end
      if (push_i && !full_o) begin
        awaited_results.push_back(serve_request(req_type_e'(req_type_i), from_router_i,
                                                address_i, word_data_i, word_tag_i));
      end
      if (psel && penable && pready) begin
        if (pwrite) begin
          case (paddr)
            SegIdAddr:      own_seg = pwdata[SegW-1:0];
            WordsInUseAddr: words_in_use = pwdata[WiuW-1:0];
            default: ;
          endcase
        end else begin
          case (paddr)
            SegIdAddr:      check_field("segment_id", own_seg, prdata);
            WordsInUseAddr: check_field("words_in_use", words_in_use, prdata);
            default: ;
          endcase
        end
      end
    end
    outstanding_o = awaited_results.size();
  end

endmodule

@@ tb/memory_node_with_tree_routing_tb.sv @@
`timescale 1ns / 100ps
// Top of the memory node testbench: clock, reset, request and config stimulus, verdict.
module memory_node_with_tree_routing_tb;
  import mntr_pkg::*;

  // Register map of the config port.
  localparam logic [2:0] SegIdAddr      = 3'h0;
  localparam logic [2:0] WordsInUseAddr = 3'h4;

  // Slowest correct run: the clearing pass, then about 1950 requests, each
  // facing at worst the longest send gap plus the longest result stall plus
  // the pipeline. CycleLimit lies well above that bound.
  localparam int unsigned CycleLimit    = 1_000_000;
  localparam int unsigned ItemsPerPhase = 320;
  localparam int unsigned NumPhases     = 6;
  // Let the block settle after the last result before the next step.
  localparam int unsigned DrainCycles   = 8;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        push_i        = 1'b0;
  logic [1:0]  req_type_i    = '0;
  logic        from_router_i = 1'b0;
  logic [63:0] address_i     = '0;
  logic [63:0] word_data_i   = '0;
  logic [7:0]  word_tag_i    = '0;
  logic        pop_i         = 1'b0;
  logic        psel          = 1'b0;
  logic        penable       = 1'b0;
  logic        pwrite        = 1'b0;
  logic [2:0]  paddr         = '0;
  logic [31:0] pwdata        = '0;

  logic        full_o;
  logic        empty_o;
  logic [2:0]  result_kind_o;
  logic [63:0] out_data_o;
  logic [7:0]  out_tag_o;
  logic [3:0]  cpu_index_o;
  logic [7:0]  up_hops_o;
  logic [23:0] down_path_o;
  logic [1:0]  link_mode_o;
  logic [63:0] link_address_o;
  logic [31:0] prdata;
  logic        pready;

  int unsigned     fail_count;
  int unsigned     outstanding;
  int unsigned     cycles     = 0;
  int unsigned     stall_left = 0;
  bit              stalls_on  = 1'b1;
  bit              gaps_on    = 1'b1;
  // Config as last written, used to aim requests at the own segment.
  logic [SegW-1:0] cur_seg;
  logic [WiuW-1:0] cur_wiu;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  memory_node_with_tree_routing dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push_i         (push_i),
    .full_o         (full_o),
    .req_type_i     (req_type_i),
    .from_router_i  (from_router_i),
    .address_i      (address_i),
    .word_data_i    (word_data_i),
    .word_tag_i     (word_tag_i),
    .pop_i          (pop_i),
    .empty_o        (empty_o),
    .result_kind_o  (result_kind_o),
    .out_data_o     (out_data_o),
    .out_tag_o      (out_tag_o),
    .cpu_index_o    (cpu_index_o),
    .up_hops_o      (up_hops_o),
    .down_path_o    (down_path_o),
    .link_mode_o    (link_mode_o),
    .link_address_o (link_address_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  mntr_node_checker #(
    .SegIdAddr      (SegIdAddr),
    .WordsInUseAddr (WordsInUseAddr)
  ) u_node_check (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push_i         (push_i),
    .full_o         (full_o),
    .req_type_i     (req_type_i),
    .from_router_i  (from_router_i),
    .address_i      (address_i),
    .word_data_i    (word_data_i),
    .word_tag_i     (word_tag_i),
    .pop_i          (pop_i),
    .empty_o        (empty_o),
    .result_kind_o  (result_kind_o),
    .out_data_o     (out_data_o),
    .out_tag_o      (out_tag_o),
    .cpu_index_o    (cpu_index_o),
    .up_hops_o      (up_hops_o),
    .down_path_o    (down_path_o),
    .link_mode_o    (link_mode_o),
    .link_address_o (link_address_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .fail_count_o   (fail_count),
    .outstanding_o  (outstanding)
  );

  // Idle length for either side: mostly none or short, now and then long.
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Result side: stall pop at random, with whole stretches of steady popping.
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      pop_i      <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      pop_i <= 1'b1;
      if (stalls_on && $urandom_range(0, 99) < 25) stall_left <= idle_len();
    end
    if ($urandom_range(0, 199) == 0) stalls_on <= !stalls_on;
  end

  // Watchdog: end the run if it hangs.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("FAIL memory_node_with_tree_routing");
      $finish;
    end
  end

  // Offer one request after an optional gap; hold it until the block takes it.
  // Leave push high on return so back-to-back requests need no extra edge.
  task automatic send_req(req_type_e rt, logic fr, logic [63:0] addr,
                          logic [63:0] data, logic [7:0] tag);
    int unsigned gap;
    gap = gaps_on ? idle_len() : 0;
    if (gap != 0) begin
      push_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push_i        <= 1'b1;
    req_type_i    <= rt;
    from_router_i <= fr;
    address_i     <= addr;
    word_data_i   <= data;
    word_tag_i    <= tag;
    do @(posedge clk_i); while (full_o !== 1'b0);
  endtask

  // One APB transfer: setup cycle, then access until pready.
  // Leave psel high on return; the caller drops it after the last transfer.
  task automatic cfg_access(logic wr, logic [2:0] addr, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
  endtask

  // Drain all results, let the pipe settle, then write and read back both registers.
  task automatic apply_config(logic [SegW-1:0] seg, logic [WiuW-1:0] wiu);
    push_i <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0);
    repeat (DrainCycles) @(posedge clk_i);
    cfg_access(1'b1, SegIdAddr, 32'(seg));
    cfg_access(1'b1, WordsInUseAddr, 32'(wiu));
    cfg_access(1'b0, SegIdAddr, '0);
    cfg_access(1'b0, WordsInUseAddr, '0);
    psel    <= 1'b0;
    penable <= 1'b0;
    cur_seg = seg;
    cur_wiu = wiu;
  endtask

  // Random request, weighted toward well-formed local traffic with hits on
  // recently written words; the rest goes out of range, to the CPUs or the router.
  task automatic random_request();
    int unsigned     pick;
    int unsigned     lim;
    logic [OffW-1:0] off;
    logic [SegW-1:0] mask;
    logic [63:0]     r64;
    logic [63:0]     data;
    logic [7:0]      tag;
    req_type_e       rt;
    logic            fr;
    lim  = (cur_wiu > MemDepth) ? MemDepth : cur_wiu;
    pick = $urandom_range(0, 99);
    r64  = {$urandom, $urandom};
    data = {$urandom, $urandom};
    tag  = 8'($urandom_range(0, 255));
    fr   = 1'($urandom_range(0, 1));
    // Nonzero segment difference: one bit, a few low bits or anything.
    case ($urandom_range(0, 2))
      0:       mask = 24'h1 << $urandom_range(0, SegW - 1);
      1:       mask = SegW'($urandom_range(1, 63));
      default: mask = SegW'($urandom_range(1, 24'hFFFFFF));
    endcase
    if (pick < 55 && lim != 0) begin
      // In range; half the time crowd into the low words so reads hit writes.
      rt  = (pick < 30) ? ReqWrite : ReqRead;
      off = ($urandom_range(0, 1) != 0)
            ? OffW'($urandom_range(0, ((lim < 32) ? lim : 32) - 1))
            : OffW'($urandom_range(0, lim - 1));
      send_req(rt, fr, {cur_seg, off}, data, tag);
    end else if (pick < 63) begin
      rt = req_type_e'($urandom_range(0, 1));
      if ($urandom_range(0, 1) != 0) begin
        // Own segment, offset at or past the limit.
        off = ($urandom_range(0, 1) != 0) ? OffW'(lim + $urandom_range(0, 15))
                                          : r64[OffW-1:0];
        if (off < lim) off = OffW'(lim);
        send_req(rt, fr, {cur_seg, off}, data, tag);
      end else begin
        // From the router but for another segment.
        send_req(rt, 1'b1, {cur_seg ^ mask, r64[OffW-1:0]}, data, tag);
      end
    end else if (pick < 73) begin
      rt = ($urandom_range(0, 1) != 0) ? ReqSignal : ReqInject;
      if ($urandom_range(0, 1) != 0) send_req(rt, fr, {cur_seg, r64[OffW-1:0]}, data, tag);
      else send_req(rt, 1'b1, r64, data, tag);
    end else if (pick < 97) begin
      // Foreign segment, not from the router: becomes a router request.
      rt = req_type_e'($urandom_range(0, 3));
      send_req(rt, 1'b0, {cur_seg ^ mask, r64[OffW-1:0]}, data, tag);
    end else begin
      send_req(req_type_e'($urandom_range(0, 3)), fr, r64, data, tag);
    end
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part: segment zero, full store.
    apply_config(24'h000000, 13'd4096);
    send_req(ReqWrite, 1'b0, 64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 8'hFF);
    send_req(ReqRead, 1'b0, 64'h0, 64'h0, 8'h00);
    send_req(ReqWrite, 1'b0, 64'd4095, 64'h0, 8'h80);
    send_req(ReqRead, 1'b0, 64'd4095, 64'hFFFF_FFFF_FFFF_FFFF, 8'hFF);
    // Offset just past the limit, and the largest offset.
    send_req(ReqRead, 1'b0, 64'd4096, 64'h0, 8'h00);
    send_req(ReqWrite, 1'b0, 64'h0000_00FF_FFFF_FFFF, 64'h1234, 8'h7F);
    // From the router for a foreign segment: out of range.
    send_req(ReqRead, 1'b1, 64'hFFFF_FF00_0000_0000, 64'h0, 8'h00);
    send_req(ReqWrite, 1'b1, 64'hFFFF_FF00_0000_0001, 64'h55, 8'h01);
    // Signals served locally: own segment, or from the router.
    send_req(ReqSignal, 1'b0, 64'h0000_0000_0000_000F, 64'hA5A5_5A5A_F0F0_0F0F, 8'h00);
    send_req(ReqInject, 1'b0, 64'h0000_00FF_FFFF_FFF0, 64'hFFFF_FFFF_FFFF_FFFF, 8'hFF);
    send_req(ReqSignal, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0001, 8'h80);
    send_req(ReqInject, 1'b1, 64'h0123_4500_0000_0007, 64'h0, 8'h00);
    // Router requests: farthest, nearest, one level up, inject with a long path.
    send_req(ReqRead, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 8'hFF);
    send_req(ReqWrite, 1'b0, 64'h0000_0100_0000_0000, 64'h0123_4567_89AB_CDEF, 8'h3C);
    send_req(ReqSignal, 1'b0, 64'h0000_0800_0000_0003, 64'hDEAD_BEEF_0000_0000, 8'h81);
    send_req(ReqInject, 1'b0, 64'h8000_0000_0000_0000, 64'h0, 8'h00);
    send_req(ReqRead, 1'b0, 64'h0000_0700_0000_0000, 64'h0, 8'hFE);
    send_req(ReqInject, 1'b0, 64'h0000_0100_0000_0000, 64'h1, 8'h01);
    // Write then read back; local read arriving from the router.
    send_req(ReqWrite, 1'b0, 64'h123, 64'hDEAD_BEEF_CAFE_F00D, 8'h7F);
    send_req(ReqRead, 1'b1, 64'h123, 64'h0, 8'h00);
    send_req(ReqRead, 1'b0, 64'd100, 64'h0, 8'h00);

    // Random phases over several settings, extremes among them.
    for (int p = 0; p < NumPhases; p++) begin
      case (p)
        0:       apply_config(24'hFFFFFF, 13'd8191);
        1:       apply_config(SegW'($urandom_range(0, 24'hFFFFFF)), 13'd0);
        2:       apply_config(SegW'($urandom_range(0, 24'hFFFFFF)), 13'd1);
        3:       apply_config(SegW'($urandom_range(0, 24'hFFFFFF)), 13'd16);
        4:       apply_config(SegW'($urandom_range(0, 24'hFFFFFF)),
                              WiuW'($urandom_range(1, 4096)));
        default: apply_config(24'h000000, 13'd4096);
      endcase
      for (int n = 0; n < ItemsPerPhase; n++) begin
        random_request();
        // Flip between gappy and back-to-back stretches now and then.
        if ($urandom_range(0, 79) == 0) gaps_on = !gaps_on;
      end
    end

    // Drop push, wait out every result, then let the pipe settle.
    push_i <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0);
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("PASS memory_node_with_tree_routing");
    end else begin
      $display("FAIL memory_node_with_tree_routing");
    end
    $finish;
  end

endmodule
